// ----- src/fspa_pkg.sv -----
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fspa_pkg;

    localparam int ADDR_FIELD_W = 32;
    localparam int SIZE_W       = 16;
    localparam int COUNT_W      = 8;
    localparam int ALIGN_W      = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    // rounded-up dividend: element_size + alignment - 1
    localparam int NUM_W        = 17;

    localparam logic [ALIGN_W-1:0] MIN_ALIGN = 13'd8;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ADDR_FIELD_W-1:0] free_address;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] slot_address;
        logic                    granted;
    } t_result;

endpackage

// ----- src/fspa_round.sv -----
// Slot size rounding: size = num - (num mod align), restoring remainder, one bit a cycle.
// Depends on fspa_pkg.
`timescale 1ns / 1ps

module fspa_round (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fspa_pkg::NUM_W-1:0]    i_num,
    input  logic [fspa_pkg::ALIGN_W-1:0]  i_align,
    output logic                          o_done,
    output logic [fspa_pkg::NUM_W-1:0]    o_size
);
    import fspa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_shift;
    logic [NUM_W-1:0]   r_num;
    logic [ALIGN_W-1:0] r_align;
    logic [ALIGN_W-1:0] r_rem;
    logic               r_done;
    logic [NUM_W-1:0]   r_size;

    logic [ALIGN_W:0]   trial;
    logic [ALIGN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_shift[NUM_W-1]};
        if (trial >= {1'b0, r_align}) begin
            n_rem = ALIGN_W'(trial - {1'b0, r_align});
        end else begin
            n_rem = trial[ALIGN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_num;
            r_num   <= i_num;
            r_align <= i_align;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[NUM_W-2:0], 1'b0};
            r_rem   <= n_rem;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_size <= r_num - NUM_W'(n_rem);
            end
        end
    end

    assign o_done = r_done;
    assign o_size = r_size;

endmodule

// ----- src/fspa_ring.sv -----
// Free-address ring storage: one write port, one read port, registered read data.
// Depends on fspa_pkg, which it imports though it uses none of its items.
`timescale 1ns / 1ps

module fspa_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import fspa_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/fixed_slot_pool_allocator.sv -----
// Top level of the fixed slot pool allocator: config registers, index control, init sequencer.
// Depends on fspa_pkg, fspa_round, fspa_ring.
//
//  channel   direction  handshake                    payload
//  command   in         start & !busy                i_cmd    (t_cmd)
//  result    out        o_result_valid, 1 cycle      o_result (t_result)
//  config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// Allocate and free never raise busy; a new command may follow every cycle
// while busy is low, and its result strobes in the cycle after acceptance (ring read latency).
// Initialize holds busy through the bit-serial size rounding, then one ring write
// per slot over a ring of element_count + 1 entries, capped at RING_DEPTH; its
// result strobes in the same cycle that busy drops.
// Reset clears the indices and loads config defaults; the ring needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module fixed_slot_pool_allocator #(
    parameter int RING_DEPTH = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fspa_pkg::t_cmd                    i_cmd,
    output logic                              o_result_valid,
    output fspa_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fspa_pkg::*;

    // only the low min(ADDR_WIDTH, 32) bits of any address are stored and compared
    localparam int SW = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
    localparam int IW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [ADDR_FIELD_W-1:0] r_base;
    logic [SIZE_W-1:0]       r_esize;
    logic [COUNT_W-1:0]      r_ecount;
    logic [ALIGN_W-1:0]      r_align;

    logic [1:0]    r_state;
    logic [IW-1:0] r_take;
    logic [IW-1:0] r_give;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_fill_cnt;
    logic [SW-1:0] r_fill_addr;
    logic [SW-1:0] r_step;

    logic r_out_valid;
    logic r_out_granted;
    logic r_out_slot;

    logic               accept;
    logic               alloc_ok;
    logic               free_ok;
    logic [ALIGN_W-1:0] align_eff;
    logic [NUM_W-1:0]   round_num;
    logic [COUNT_W:0]   count_raw;
    logic [LW-1:0]      count_sat;
    logic [LW-1:0]      len_m1;
    logic               fill_last;
    logic               round_done;
    logic [NUM_W-1:0]   round_size;

    logic          ring_we;
    logic [IW-1:0] ring_waddr;
    logic [SW-1:0] ring_wdata;
    logic [SW-1:0] ring_rdata;

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] nxt;
        nxt = LW'(idx) + LW'(1);
        if (nxt >= len) begin
            return '0;
        end
        return nxt[IW-1:0];
    endfunction

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign alloc_ok  = (i_cmd.mode == MODE_ALLOC) && (r_take != r_give);
    assign free_ok   = (i_cmd.mode == MODE_FREE) && (i_cmd.free_address[SW-1:0] != '0);
    assign align_eff = (r_align < MIN_ALIGN) ? MIN_ALIGN : r_align;
    assign round_num = NUM_W'(r_esize) + NUM_W'(align_eff) - NUM_W'(1);
    assign count_raw = {1'b0, r_ecount} + (COUNT_W + 1)'(1);
    assign count_sat = (32'(count_raw) > RING_DEPTH) ? LW'(RING_DEPTH) : LW'(count_raw);
    assign len_m1    = r_len - LW'(1);
    assign fill_last = (r_fill_cnt == len_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_esize  <= SIZE_W'(16);
            r_ecount <= COUNT_W'(255);
            r_align  <= ALIGN_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base   <= i_cfg_data;
                CFG_SIZE:  r_esize  <= i_cfg_data[SIZE_W-1:0];
                CFG_COUNT: r_ecount <= i_cfg_data[COUNT_W-1:0];
                CFG_ALIGN: r_align  <= i_cfg_data[ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    fspa_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_cmd.mode == MODE_INIT)),
        .i_num   (round_num),
        .i_align (align_eff),
        .o_done  (round_done),
        .o_size  (round_size)
    );

    always_comb begin
        if (r_state == ST_FILL) begin
            ring_we    = 1'b1;
            ring_waddr = r_fill_cnt[IW-1:0];
            ring_wdata = r_fill_addr;
        end else begin
            ring_we    = accept && free_ok;
            ring_waddr = r_give;
            ring_wdata = i_cmd.free_address[SW-1:0];
        end
    end

    fspa_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SW),
        .IDX_W (IW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (r_take),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_take        <= '0;
            r_give        <= '0;
            r_len         <= LW'(1);
            r_fill_cnt    <= '0;
            r_out_valid   <= 1'b0;
            r_out_granted <= 1'b0;
            r_out_slot    <= 1'b0;
        end else begin
            r_out_valid   <= 1'b0;
            r_out_granted <= 1'b0;
            r_out_slot    <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_cmd.mode == MODE_INIT) begin
                            r_len   <= count_sat;
                            r_state <= ST_DIV;
                        end else begin
                            r_out_valid   <= 1'b1;
                            r_out_granted <= alloc_ok || free_ok;
                            r_out_slot    <= alloc_ok;
                            if (alloc_ok) begin
                                r_take <= advance(r_take, r_len);
                            end
                            if (free_ok) begin
                                r_give <= advance(r_give, r_len);
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (round_done) begin
                        r_fill_cnt <= '0;
                        r_state    <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    r_fill_cnt <= r_fill_cnt + LW'(1);
                    if (fill_last) begin
                        r_take        <= '0;
                        r_give        <= len_m1[IW-1:0];
                        r_out_valid   <= 1'b1;
                        r_out_granted <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // fill address generator: base + size*n built by accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && round_done) begin
            r_fill_addr <= r_base[SW-1:0];
            r_step      <= SW'(round_size);
        end else if (r_state == ST_FILL) begin
            r_fill_addr <= r_fill_addr + r_step;
        end
    end

    assign o_result_valid        = r_out_valid;
    assign o_result.granted      = r_out_granted;
    assign o_result.slot_address = r_out_slot ? ADDR_FIELD_W'(ring_rdata) : '0;

    a_no_result_while_rounding : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_result_valid)
        else $error("result strobe during size rounding");

    a_alloc_grant : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.mode == MODE_ALLOC && r_take != r_give)
            |=> (o_result_valid && o_result.granted))
        else $error("allocate from non-empty ring not granted");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_fill_cnt < r_len))
        else $error("fill ran past ring length");

    a_index_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (LW'(r_take) < r_len && LW'(r_give) < r_len))
        else $error("ring index outside ring length");

endmodule

// ----- sim/tb_fixed_slot_pool_allocator.sv -----
// Self-checking testbench for fixed_slot_pool_allocator: directed and random command
// streams, checked against an in-bench model of the free-slot ring. Needs fspa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_fixed_slot_pool_allocator;
    import fspa_pkg::*;

    localparam logic [1:0] MODE_NOP      = 2'd3;
    localparam int         RING_SLOTS    = 256;
    localparam int         WATCHDOG_MAX  = 5000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         PRINT_CAP     = 40;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd       = '0;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    fixed_slot_pool_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model of the pool
    logic [ADDR_FIELD_W-1:0] slot_ring [RING_SLOTS];
    int                      take_idx;
    int                      give_idx;
    int                      ring_len;
    logic [ADDR_FIELD_W-1:0] cfg_base;
    logic [SIZE_W-1:0]       cfg_size;
    logic [COUNT_W-1:0]      cfg_count;
    logic [ALIGN_W-1:0]      cfg_align;

    // config as last loaded, seen by the stimulus generator
    logic [ADDR_FIELD_W-1:0] gen_base;
    logic [SIZE_W-1:0]       gen_size;
    logic [COUNT_W-1:0]      gen_count;
    logic [ALIGN_W-1:0]      gen_align;

    t_cmd    cmd_backlog[$];
    t_result pending_replies[$];

    int sender_idle_pct = 0;
    int err_count       = 0;
    int quiet_cycles    = 0;
    int cmds_taken      = 0;
    int replies_checked = 0;
    int allocs_granted  = 0;
    int allocs_empty    = 0;
    int frees_pushed    = 0;
    int inits_done      = 0;
    int config_loads    = 0;
    int idle_plan[4]    = '{0, 80, 0, 31};

    function automatic int slot_stride(input logic [SIZE_W-1:0] size,
                                       input logic [ALIGN_W-1:0] align);
        int a;
        a = (align < MIN_ALIGN) ? int'(MIN_ALIGN) : int'(align);
        return ((int'(size) + a - 1) / a) * a;
    endfunction

    function automatic int ring_advance(input int idx);
        return (idx + 1 >= ring_len) ? 0 : idx + 1;
    endfunction

    function automatic t_result predict_pool_reply(input t_cmd c);
        t_result r;
        int      stride;
        int      n;
        r = '0;
        case (c.mode)
            MODE_ALLOC: begin
                if (take_idx != give_idx) begin
                    r.slot_address = slot_ring[take_idx];
                    r.granted      = 1'b1;
                    take_idx       = ring_advance(take_idx);
                    allocs_granted++;
                end else begin
                    allocs_empty++;
                end
            end
            MODE_FREE: begin
                if (c.free_address != '0) begin
                    slot_ring[give_idx] = c.free_address;
                    give_idx            = ring_advance(give_idx);
                    r.granted           = 1'b1;
                    frees_pushed++;
                end
            end
            MODE_INIT: begin
                stride   = slot_stride(cfg_size, cfg_align);
                ring_len = int'(cfg_count) + 1;
                for (n = 0; n < ring_len; n++)
                    slot_ring[n] = cfg_base + ADDR_FIELD_W'(stride * n);
                take_idx  = 0;
                give_idx  = ring_len - 1;
                r.granted = 1'b1;
                inits_done++;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP)
            $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // driver: feeds the command port from the backlog and runs the model
    always @(posedge i_clk) begin
        logic nxt_start;
        if (!i_rst_n) begin
            foreach (slot_ring[k]) slot_ring[k] = '0;
            take_idx  = 0;
            give_idx  = 0;
            ring_len  = 1;
            cfg_base  = '0;
            cfg_size  = 16'd16;
            cfg_count = 8'd255;
            cfg_align = 13'd8;
            start <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:  cfg_base  = i_cfg_data[ADDR_FIELD_W-1:0];
                    CFG_SIZE:  cfg_size  = i_cfg_data[SIZE_W-1:0];
                    CFG_COUNT: cfg_count = i_cfg_data[COUNT_W-1:0];
                    CFG_ALIGN: cfg_align = i_cfg_data[ALIGN_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pending_replies.push_back(predict_pool_reply(i_cmd));
                cmds_taken++;
            end
            nxt_start = start && busy;
            if (!nxt_start && cmd_backlog.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                i_cmd <= cmd_backlog.pop_front();
                nxt_start = 1'b1;
            end
            start <= nxt_start;
        end
    end

    // monitor: every strobe must match the oldest outstanding reply
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no command outstanding",
                                o_result.slot_address, '0);
            end else begin
                want = pending_replies.pop_front();
                if (o_result.slot_address !== want.slot_address)
                    report_mismatch("slot_address", o_result.slot_address,
                                    want.slot_address);
                if (o_result.granted !== want.granted)
                    report_mismatch("granted", 32'(o_result.granted), 32'(want.granted));
                replies_checked++;
            end
        end
    end

    // watchdog: ends the run after too long without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog: no transaction for %0d cycles, %0d replies outstanding",
                     quiet_cycles, pending_replies.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_cmd(input logic [1:0] mode, input logic [31:0] addr);
        t_cmd c;
        c.mode         = mode;
        c.free_address = addr;
        cmd_backlog.push_back(c);
    endtask

    // wait until the block has nothing in flight; sampled mid-cycle so that
    // a command issued at the last edge is already visible on start
    task automatic drain_pool();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || busy || pending_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // upper bits above each register's width carry junk; the block must drop them
    task automatic load_config(input logic [31:0] base, input logic [15:0] size,
                               input logic [7:0] count, input logic [12:0] align);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_BASE, base);
        write_reg(CFG_SIZE, {junk[31:16], size});
        write_reg(CFG_COUNT, {junk[31:8], count});
        write_reg(CFG_ALIGN, {junk[31:13], align});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gen_base  = base;
        gen_size  = size;
        gen_count = count;
        gen_align = align;
        config_loads++;
    endtask

    // init, drain burst, then a mix dominated by allocates and frees of real slot addresses
    task automatic fill_random(input int n_cmds);
        int          k;
        int          r;
        int          burst;
        int          stride;
        logic [31:0] addr;
        stride = slot_stride(gen_size, gen_align);
        push_cmd(MODE_INIT, $urandom);
        burst = (int'(gen_count) + 2 < 20) ? int'(gen_count) + 2 : 20;
        for (k = 0; k < burst; k++) push_cmd(MODE_ALLOC, $urandom);
        for (k = burst + 1; k < n_cmds; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                push_cmd(MODE_ALLOC, $urandom);
            end else if (r < 85) begin
                addr = gen_base + 32'(stride * $urandom_range(0, gen_count));
                push_cmd(MODE_FREE, addr);
            end else if (r < 90) begin
                push_cmd(MODE_FREE, 32'h0);
            end else if (r < 95) begin
                push_cmd(MODE_FREE, $urandom);
            end else if (r < 98) begin
                push_cmd(MODE_NOP, $urandom);
            end else begin
                push_cmd(MODE_INIT, $urandom);
            end
        end
    endtask

    initial begin
        int          ph;
        logic [31:0] base;
        logic [15:0] size;
        logic [7:0]  count;
        logic [12:0] align;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default config; pool untouched, then first init
        push_cmd(MODE_ALLOC, 32'hFFFF_FFFF);  // empty before init
        push_cmd(MODE_FREE, 32'h0);           // zero address ignored
        push_cmd(MODE_NOP, 32'hFFFF_FFFF);
        push_cmd(MODE_FREE, 32'hFFFF_FFFF);
        push_cmd(MODE_ALLOC, 32'h0);
        push_cmd(MODE_INIT, 32'h0);
        push_cmd(MODE_ALLOC, 32'h0);
        push_cmd(MODE_ALLOC, 32'h0);
        push_cmd(MODE_FREE, 32'hFFFF_FFFF);
        push_cmd(MODE_FREE, 32'h1);
        push_cmd(MODE_ALLOC, 32'h0);
        drain_pool();

        // zero count: one-entry ring that is always empty; alignment of zero
        load_config(32'hFFFF_FFF0, 16'd1, 8'd0, 13'd0);
        push_cmd(MODE_INIT, 32'h0);
        push_cmd(MODE_ALLOC, 32'h0);
        push_cmd(MODE_FREE, 32'h55);
        push_cmd(MODE_ALLOC, 32'h0);
        drain_pool();

        // widest size, non-power-of-two max alignment, addresses wrap past 2^32
        load_config(32'hFFFF_FF00, 16'hFFFF, 8'd3, 13'h1FFF);
        push_cmd(MODE_INIT, 32'h0);
        repeat (4) push_cmd(MODE_ALLOC, 32'h0);
        push_cmd(MODE_FREE, 32'hFFFF_FFFF);
        push_cmd(MODE_ALLOC, 32'h0);
        drain_pool();

        for (ph = 0; ph < 8; ph++) begin
            sender_idle_pct = idle_plan[ph % 4];
            base = $urandom;
            case ($urandom_range(0, 3))
                0: size = 16'd1;
                1: size = 16'hFFFF;
                2: size = 16'd0;
                default: size = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: align = 13'(1 << $urandom_range(0, 12));
                1: align = 13'($urandom_range(0, 7));
                2: align = $urandom;
                default: align = 13'h1FFF;
            endcase
            count = 8'($urandom_range(1, 12));
            if (ph == 1) count = 8'd255;
            if (ph == 2) count = 8'($urandom_range(20, 60));
            if (ph == 4) count = 8'd0;
            if (ph == 5) base = 32'hFFFF_FFFF;
            if (ph == 6) align = 13'd4096;
            load_config(base, size, count, align);
            fill_random(60);
            drain_pool();
        end

        repeat (10) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never seen", 32'(pending_replies.size()), '0);

        $display("Covered %0d commands over %0d config loads: %0d inits, %0d frees pushed",
                 cmds_taken, config_loads, inits_done, frees_pushed);
        $display("Allocates: %0d granted, %0d on empty pool; %0d replies checked, %0d errors",
                 allocs_granted, allocs_empty, replies_checked, err_count);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
